/* design/kmid_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmid_pkg
// Shared widths, defaults and types for the key matrix debounce unit.
// ----------------------------------------------------------------------------
package kmid_pkg;

    localparam int ROW_W    = 3;
    localparam int COL_W    = 3;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int STATUS_W = CNT_W + 1;

    localparam int ROWS_DEF = 8;
    localparam int COLS_DEF = 8;

    localparam logic [CNT_W-1:0] TICKS_RESET = 7'd5;

    // Per-key status word: hysteresis count above the inverted stable level
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             inv;
    } status_t;

    // Result of one key update
    typedef struct packed {
        logic    fire;
        status_t wr_status;
    } upd_t;

endpackage

/* design/kmid_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmid_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read-first: a same-address write is seen on the next read only
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/kmid_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmid_update
// Integrator step for one key: count up on disagreement, down on agreement.
// ----------------------------------------------------------------------------
module kmid_update (
    input  kmid_pkg::status_t             cur_status,
    input  logic                          level,
    input  logic [kmid_pkg::CNT_W-1:0]    debounce_ticks,
    output kmid_pkg::upd_t                upd
);

    import kmid_pkg::*;

    logic [CNT_W:0] cnt_new;

    always_comb
    begin
        // stored inv equal to the sample means the sample disagrees
        if (level == cur_status.inv)
        begin
            cnt_new = {1'b0, cur_status.cnt} + 1'b1;
        end
        else if (cur_status.cnt != '0)
        begin
            cnt_new = {1'b0, cur_status.cnt} - 1'b1;
        end
        else
        begin
            cnt_new = '0;
        end

        upd.fire = (cnt_new >= {1'b0, debounce_ticks});
        if (upd.fire)
        begin
            upd.wr_status.cnt = '0;
            upd.wr_status.inv = ~level;
        end
        else
        begin
            upd.wr_status.cnt = cnt_new[CNT_W-1:0];
            upd.wr_status.inv = cur_status.inv;
        end
    end

endmodule

/* design/key_matrix_integrator_debounce_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_integrator_debounce_unit
// Integrator debounce over a scanned key matrix, one status word per key.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while the result side is not stalled (row, col,
// level; level 0 = pressed) and emits a transfer of key_index/new_level
// whenever a key's debounced level flips. An accepted sample has its status
// word read from the status RAM into stage 1, then its update goes into the
// result register. Back-to-back samples of the same key are covered by a
// forwarding register holding the last write. Samples outside ROWS x COLS are
// accepted and dropped. All keys read as released after reset, through
// per-key valid flops, so no clearing pass is needed. debounce_ticks resets to
// 5 and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module key_matrix_integrator_debounce_unit #(
    parameter int ROWS = kmid_pkg::ROWS_DEF,
    parameter int COLS = kmid_pkg::COLS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic [kmid_pkg::CNT_W-1:0]   cfg_wr_data,
    // sample channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [kmid_pkg::ROW_W-1:0]   row,
    input  logic [kmid_pkg::COL_W-1:0]   col,
    input  logic                         level,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [kmid_pkg::IDX_W-1:0]   key_index,
    output logic                         new_level
);

    import kmid_pkg::*;

    // Only rows the 3-bit row field can reach take storage
    localparam int EROWS = (ROWS < (2 ** ROW_W)) ? ROWS : (2 ** ROW_W);
    localparam int KEYS  = EROWS * COLS;
    localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;

    logic [CNT_W-1:0] ticks_reg;

    // stage 1: item waiting for its RAM read data
    logic             s1_valid_reg;
    logic [KEY_W-1:0] s1_key_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s1_level_reg;

    // last write, for forwarding past the read-first RAM
    logic             lw_valid_reg;
    logic [KEY_W-1:0] lw_key_reg;
    status_t          lw_status_reg;

    logic [KEYS-1:0]  key_valid_reg;

    logic             out_valid_reg;
    logic [IDX_W-1:0] key_index_reg;
    logic             new_level_reg;

    logic [15:0]      key_full;
    logic             in_range;
    logic             in_xfer;
    logic             adv1;
    logic             wr_en;
    logic [STATUS_W-1:0] rd_data;
    status_t          cur_status;
    upd_t             upd;

    // ---- input side ----
    assign key_full = 16'(row) * 16'(COLS) + 16'(col);
    assign in_range = ({5'd0, row} < 8'(ROWS)) && ({5'd0, col} < 8'(COLS));

    // stage 1 moves on whenever the result register is free or draining
    assign adv1     = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || adv1;
    assign in_xfer  = in_valid && in_ready;
    assign wr_en    = s1_valid_reg && adv1;

    kmid_ram #(
        .WIDTH (STATUS_W),
        .DEPTH (KEYS)
    ) u_status_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_key_reg),
        .wr_data (upd.wr_status),
        .rd_en   (in_xfer),
        .rd_addr (key_full[KEY_W-1:0]),
        .rd_data (rd_data)
    );

    // ---- current status: forwarded write, RAM word, or reset value ----
    always_comb
    begin
        if (lw_valid_reg && (lw_key_reg == s1_key_reg))
        begin
            cur_status = lw_status_reg;
        end
        else if (key_valid_reg[s1_key_reg])
        begin
            cur_status = status_t'(rd_data);
        end
        else
        begin
            cur_status = '0;
        end
    end

    kmid_update u_update (
        .cur_status     (cur_status),
        .level          (s1_level_reg),
        .debounce_ticks (ticks_reg),
        .upd            (upd)
    );

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg     <= TICKS_RESET;
            s1_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            key_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ticks_reg <= cfg_wr_data;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid && in_range;
            end
            if (wr_en)
            begin
                lw_valid_reg              <= 1'b1;
                key_valid_reg[s1_key_reg] <= 1'b1;
            end
            if (adv1)
            begin
                out_valid_reg <= s1_valid_reg && upd.fire;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_key_reg   <= key_full[KEY_W-1:0];
            s1_idx_reg   <= key_full[IDX_W-1:0];
            s1_level_reg <= level;
        end
        if (wr_en)
        begin
            lw_key_reg    <= s1_key_reg;
            lw_status_reg <= upd.wr_status;
        end
        if (adv1)
        begin
            key_index_reg <= s1_idx_reg;
            new_level_reg <= s1_level_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign key_index = key_index_reg;
    assign new_level = new_level_reg;

endmodule

/* bench/tb_key_matrix_integrator_debounce_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_matrix_integrator_debounce_unit
// Self-checking bench for the key matrix integrator debounce unit.
// ----------------------------------------------------------------------------
// A short table of hand-written samples covers both corners of the matrix, a
// key reaching its tick count in each direction, a zero tick count, and a
// tick count lowered under a key that is part way through counting. A series
// of phases with different tick counts follows. Each phase mostly holds
// bursts of samples on one key with occasional bounces, mixed with stray
// samples across the matrix. Every accepted sample goes through a local model
// of the per-key integrators. Each flip it predicts is queued and compared
// with the next result transfer. Both sides stall in random bursts, except
// in the second and the final phase.
// ----------------------------------------------------------------------------
module tb_key_matrix_integrator_debounce_unit;

    import kmid_pkg::*;

    localparam int NKEYS        = ROWS_DEF * COLS_DEF;
    localparam int DRAIN_CYCLES = 8;         // margin for the pipeline to empty
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DIR_N        = 28;
    localparam int PHASE_N      = 8;

    typedef enum logic [1:0] {STEP_SAMPLE, STEP_SET_TICKS} step_kind_e;

    // How a table row is checked: by the model, as silent, or against a typed result
    typedef enum logic [1:0] {CHK_PREDICT, CHK_SILENT, CHK_FLIP} check_mode_e;

    typedef struct packed {
        step_kind_e        kind;
        logic [CNT_W-1:0]  ticks;
        logic [ROW_W-1:0]  r;
        logic [COL_W-1:0]  c;
        logic              lv;
        check_mode_e       mode;
        logic [IDX_W-1:0]  k;
        logic              nl;
    } dir_step_t;

    typedef struct packed {
        logic [IDX_W-1:0] k;
        logic             nl;
    } key_flip_t;

    typedef struct packed {
        logic [CNT_W-1:0] ticks;
        logic [15:0]      samples;
        logic [7:0]       idle;
    } phase_t;

    // Reset tick count is 5
    localparam dir_step_t DIR_TAB [DIR_N] = '{
        // key 0 pressed: four samples build up, the fifth flips it
        '{STEP_SAMPLE,    7'd0,   3'd0, 3'd0, 1'b0, CHK_SILENT,  6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd0, 3'd0, 1'b0, CHK_SILENT,  6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd0, 3'd0, 1'b0, CHK_SILENT,  6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd0, 3'd0, 1'b0, CHK_SILENT,  6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd0, 3'd0, 1'b0, CHK_FLIP,    6'd0,  1'b0},
        // far corner: released sample agrees, then pressed five times
        '{STEP_SAMPLE,    7'd0,   3'd7, 3'd7, 1'b1, CHK_SILENT,  6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd7, 3'd7, 1'b0, CHK_SILENT,  6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd7, 3'd7, 1'b0, CHK_SILENT,  6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd7, 3'd7, 1'b0, CHK_SILENT,  6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd7, 3'd7, 1'b0, CHK_SILENT,  6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd7, 3'd7, 1'b0, CHK_FLIP,    6'd63, 1'b0},
        // bounce on key 0: count up, then back down
        '{STEP_SAMPLE,    7'd0,   3'd0, 3'd0, 1'b1, CHK_PREDICT, 6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd0, 3'd0, 1'b1, CHK_PREDICT, 6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd0, 3'd0, 1'b0, CHK_PREDICT, 6'd0,  1'b0},
        // key 9 left with a count of three
        '{STEP_SAMPLE,    7'd0,   3'd1, 3'd1, 1'b0, CHK_PREDICT, 6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd1, 3'd1, 1'b0, CHK_PREDICT, 6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd1, 3'd1, 1'b0, CHK_PREDICT, 6'd0,  1'b0},
        // tick count dropped below it: an agreeing sample still fires
        '{STEP_SET_TICKS, 7'd2,   3'd0, 3'd0, 1'b0, CHK_SILENT,  6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd1, 3'd1, 1'b1, CHK_FLIP,    6'd9,  1'b1},
        // zero ticks: every sample reports
        '{STEP_SET_TICKS, 7'd0,   3'd0, 3'd0, 1'b0, CHK_SILENT,  6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd0, 3'd5, 1'b1, CHK_FLIP,    6'd5,  1'b1},
        '{STEP_SAMPLE,    7'd0,   3'd0, 3'd5, 1'b0, CHK_FLIP,    6'd5,  1'b0},
        '{STEP_SET_TICKS, 7'd127, 3'd0, 3'd0, 1'b0, CHK_SILENT,  6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd7, 3'd0, 1'b0, CHK_PREDICT, 6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd0, 3'd7, 1'b1, CHK_PREDICT, 6'd0,  1'b0},
        // single tick: agreeing sample holds, first press flips
        '{STEP_SET_TICKS, 7'd1,   3'd0, 3'd0, 1'b0, CHK_SILENT,  6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd3, 3'd4, 1'b1, CHK_SILENT,  6'd0,  1'b0},
        '{STEP_SAMPLE,    7'd0,   3'd3, 3'd4, 1'b0, CHK_FLIP,    6'd28, 1'b0}
    };

    // Random phases; the last one runs with no stalls on either side
    localparam phase_t PHASES [PHASE_N] = '{
        '{7'd3,   16'd110, 8'd30},
        '{7'd1,   16'd90,  8'd0},
        '{7'd127, 16'd330, 8'd20},
        '{7'd0,   16'd60,  8'd40},
        '{7'd2,   16'd90,  8'd25},
        '{7'd8,   16'd100, 8'd15},
        '{7'd4,   16'd80,  8'd30},
        '{7'd5,   16'd70,  8'd0}
    };

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]   cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [ROW_W-1:0]   row         = '0;
    logic [COL_W-1:0]   col         = '0;
    logic               level       = 1'b1;
    logic               out_valid;
    logic               out_ready   = 1'b1;
    logic [IDX_W-1:0]   key_index;
    logic               new_level;

    // Local copy of the per-key integrators and the tick count
    status_t            key_state [NKEYS];
    logic [CNT_W-1:0]   ticks_now;
    key_flip_t          flips_due [$];

    int                 idle_pct;
    int                 errors      = 0;
    int                 samples_sent;
    int                 flips_seen  = 0;
    int                 tick_writes;
    int                 cycles      = 0;

    key_matrix_integrator_debounce_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .row         (row),
        .col         (col),
        .level       (level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .key_index   (key_index),
        .new_level   (new_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake or a missing flip ends here
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d flips outstanding", $time, flips_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Integrator update for one accepted sample. Bit inv holds the inverted
    // stable level, so a sample equal to inv disagrees with the stable level.
    function automatic void debounce_step(input logic [ROW_W-1:0] r,
                                          input logic [COL_W-1:0] c,
                                          input logic lv,
                                          output bit fires,
                                          output logic [IDX_W-1:0] k);
        int               idx;
        logic [CNT_W:0]   cnt;
        fires = 1'b0;
        k     = '0;
        if (r >= ROWS_DEF || c >= COLS_DEF)
            return;
        idx = int'(r) * COLS_DEF + int'(c);
        k   = IDX_W'(idx);
        cnt = {1'b0, key_state[idx].cnt};
        if (lv == key_state[idx].inv)
            cnt = cnt + 1'b1;
        else if (cnt != 0)
            cnt = cnt - 1'b1;
        if (cnt >= {1'b0, ticks_now})
        begin
            fires                 = 1'b1;
            key_state[idx].cnt    = '0;
            key_state[idx].inv    = ~lv;
        end
        else
            key_state[idx].cnt    = cnt[CNT_W-1:0];
    endfunction

    // One sample transfer, with an optional gap before it. Valid is left high
    // so that a following sample goes out on the next edge.
    task automatic send_sample(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                               input logic lv, input check_mode_e mode,
                               input logic [IDX_W-1:0] k_typed, input logic nl_typed);
        bit               fires;
        logic [IDX_W-1:0] k;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        row      <= r;
        col      <= c;
        level    <= lv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        samples_sent++;
        debounce_step(r, c, lv, fires, k);
        case (mode)
            CHK_FLIP:    flips_due.push_back('{k: k_typed, nl: nl_typed});
            CHK_SILENT:  ;
            default:     if (fires) flips_due.push_back('{k: k, nl: lv});
        endcase
    endtask

    // Park the input side and let every flip in flight come out
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        @(posedge clk);
        while (flips_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_ticks(input logic [CNT_W-1:0] t);
        drain_pipeline();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= t;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        ticks_now    = t;
        tick_writes++;
    endtask

    // Result side: random stall bursts, reading idle_pct from the stimulus
    initial
    begin : result_stall
        int unsigned hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 1)
                hold--;
            else if (hold == 1)
            begin
                hold = 0;
                out_ready <= 1'b1;
            end
            else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            begin
                hold = $urandom_range(1, 14);
                out_ready <= 1'b0;
            end
        end
    end

    // Each result transfer is matched against the oldest predicted flip
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            flips_seen++;
            if (flips_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected flip, expected none, actual key %0d level %0b",
                         $time, key_index, new_level);
            end
            else
            begin
                if (key_index !== flips_due[0].k)
                begin
                    errors++;
                    $display("%0t: key_index expected %0d actual %0d",
                             $time, flips_due[0].k, key_index);
                end
                if (new_level !== flips_due[0].nl)
                begin
                    errors++;
                    $display("%0t: new_level expected %0b actual %0b",
                             $time, flips_due[0].nl, new_level);
                end
                void'(flips_due.pop_front());
            end
        end
    end

    initial
    begin : stimulus
        int               sent;
        int               burst_len;
        logic [IDX_W-1:0] burst_key;
        logic             burst_lvl;
        logic [IDX_W-1:0] stray;

        samples_sent = 0;
        tick_writes  = 0;
        idle_pct     = 0;
        ticks_now    = TICKS_RESET;
        foreach (key_state[i])
            key_state[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        idle_pct = 30;
        for (int i = 0; i < DIR_N; i++)
        begin
            if (DIR_TAB[i].kind == STEP_SET_TICKS)
                set_ticks(DIR_TAB[i].ticks);
            else
                send_sample(DIR_TAB[i].r, DIR_TAB[i].c, DIR_TAB[i].lv,
                            DIR_TAB[i].mode, DIR_TAB[i].k, DIR_TAB[i].nl);
        end

        // Random phases: mostly held presses or releases with some bounce,
        // the remainder stray samples anywhere in the matrix
        for (int p = 0; p < PHASE_N; p++)
        begin
            set_ticks(PHASES[p].ticks);
            idle_pct = int'(PHASES[p].idle);
            sent     = 0;
            while (sent < int'(PHASES[p].samples))
            begin
                if ($urandom_range(9) < 7)
                begin
                    burst_key = IDX_W'($urandom_range(NKEYS - 1));
                    burst_lvl = 1'($urandom_range(1));
                    burst_len = int'(ticks_now) + int'(ticks_now) / 3
                              + int'($urandom_range(1, 4));
                    for (int j = 0; j < burst_len && sent < int'(PHASES[p].samples); j++)
                    begin
                        send_sample(burst_key[5:3], burst_key[2:0],
                                    ($urandom_range(99) < 12) ? ~burst_lvl : burst_lvl,
                                    CHK_PREDICT, '0, 1'b0);
                        sent++;
                    end
                end
                else
                begin
                    stray = IDX_W'($urandom_range(NKEYS - 1));
                    send_sample(stray[5:3], stray[2:0], 1'($urandom_range(1)),
                                CHK_PREDICT, '0, 1'b0);
                    sent++;
                end
            end
        end

        drain_pipeline();

        $display("Sent %0d samples over %0d tick count writes, ticks 0 to 127.",
                 samples_sent, tick_writes);
        $display("Checked %0d debounced key flips, %0d errors.", flips_seen, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
design/kmid_pkg.sv
design/kmid_ram.sv
design/kmid_update.sv
design/key_matrix_integrator_debounce_unit.sv
bench/tb_key_matrix_integrator_debounce_unit.sv
